// File: hw/rtl/hpn_pkg.sv
// Shared types and constants for the Hartley point normalizer.
`default_nettype none
package hpn_pkg;

	localparam logic [32:0] SQRT2_Q32 = 33'h1_6A09_E668;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO     = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic        [31:0] scale;
		logic        [10:0] point_count;
		logic        [1:0]  status;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP_X,
		ST_DIV_X,
		ST_FIN_X,
		ST_DIV_Y,
		ST_FIN_Y,
		ST_RD,
		ST_MAG,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_ACC,
		ST_PREP_S,
		ST_DIV_S,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/hartley_point_normalizer_unit.sv
// Hartley isotropic point normalizer: centroid and sqrt(2)/mean-distance scale.
//
// Points are taken one per cycle while busy is low (start high). A point beyond
// MAX_POINTS is dropped and flags status 2. After the point marked last, busy rises
// and one restoring compare/subtract unit serves all divisions and square roots:
// two centroid divisions, then per stored point one memory read, two square steps
// and a square root, then a final division, skipped when the distance sum is zero.
// The result appears on result for exactly one cycle with done high; the receiver
// cannot stall, and busy falls in the following cycle.
`default_nettype none
module hartley_point_normalizer_unit import hpn_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire point_t  point,
	output logic         busy,
	output logic         done,
	output result_t      result
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = 32 + CW;          // coordinate sums
	localparam int DSW = 33 + CW;         // distance sum
	localparam int NW = 34 + CW;          // dividend / quotient
	localparam int RW = NW + 1;           // shared remainder
	localparam int KW = $clog2(NW);

	state_t state_q, state_d;

	logic [63:0]            mem [MAX_POINTS];
	logic [63:0]            rd_q;
	logic signed [SW-1:0]   sum_x_q, sum_y_q;
	logic [CW-1:0]          n_q, idx_q;
	logic                   ovf_q;
	logic [RW-1:0]          rem_q;
	logic [NW-1:0]          quo_q;
	logic [RW-1:0]          den_q;
	logic [KW-1:0]          cnt_q;
	logic                   neg_q;
	logic [31:0]            cx_q, cy_q;
	logic [32:0]            ux_q, uy_q;
	logic [65:0]            rad_q;
	logic [32:0]            root_q;
	logic [DSW-1:0]         dsum_q;

	logic                   accept, full;
	logic [RW-1:0]          sub_a, sub_b;
	logic [RW:0]            diff;
	logic                   ge;
	logic signed [32:0]     dx, dy;
	logic [SW-1:0]          abs_y;
	logic [CW+10:0]         n_ext;

	assign accept = start && !busy;
	assign full   = (n_q == CW'(MAX_POINTS));

	// shared compare/subtract: division shifts in one bit, square root two
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = {rem_q[RW-3:0], rad_q[65:64]};
			sub_b = RW'({root_q, 2'b01});
		end else begin
			sub_a = {rem_q[RW-2:0], quo_q[NW-1]};
			sub_b = den_q;
		end
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		ge   = !diff[RW];
	end

	assign dx    = 33'(signed'(rd_q[63:32])) - 33'(signed'(cx_q));
	assign dy    = 33'(signed'(rd_q[31:0])) - 33'(signed'(cy_q));
	assign abs_y = sum_y_q[SW-1] ? SW'(-sum_y_q) : SW'(sum_y_q);
	assign n_ext = {11'b0, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != ST_IDLE);
		done    = (state_q == ST_DONE);
		case (state_q)
			ST_IDLE:   if (accept && point.last_point) state_d = ST_PREP_X;
			ST_PREP_X: state_d = ST_DIV_X;
			ST_DIV_X:  if (cnt_q == '0) state_d = ST_FIN_X;
			ST_FIN_X:  state_d = ST_DIV_Y;
			ST_DIV_Y:  if (cnt_q == '0) state_d = ST_FIN_Y;
			ST_FIN_Y:  state_d = ST_RD;
			ST_RD:     state_d = ST_MAG;
			ST_MAG:    state_d = ST_SQX;
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == '0) state_d = ST_ACC;
			ST_ACC:    state_d = (idx_q + 1'b1 == n_q) ? ST_PREP_S : ST_RD;
			ST_PREP_S: state_d = (dsum_q == '0) ? ST_DONE : ST_DIV_S;
			ST_DIV_S:  if (cnt_q == '0) state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// point store
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && !full)
			mem[n_q[AW-1:0]] <= {point.x_coord, point.y_coord};
		if (state_q == ST_RD)
			rd_q <= mem[idx_q[AW-1:0]];
	end

	// control counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			n_q     <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						sum_x_q <= sum_x_q + SW'(point.x_coord);
						sum_y_q <= sum_y_q + SW'(point.y_coord);
						n_q     <= n_q + 1'b1;
					end
				end
				ST_PREP_X, ST_FIN_X, ST_PREP_S: cnt_q <= KW'(NW - 1);
				ST_DIV_X, ST_DIV_Y, ST_DIV_S, ST_SQRT: cnt_q <= cnt_q - 1'b1;
				ST_FIN_Y: idx_q <= '0;
				ST_SQY:   cnt_q <= KW'(32);
				ST_ACC:   idx_q <= idx_q + 1'b1;
				ST_DONE: begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					n_q     <= '0;
					ovf_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP_X: begin
				neg_q <= sum_x_q[SW-1];
				quo_q <= NW'(sum_x_q[SW-1] ? SW'(-sum_x_q) : SW'(sum_x_q)) + NW'(n_q >> 1);
				rem_q <= '0;
				den_q <= RW'(n_q);
			end
			ST_DIV_X, ST_DIV_Y, ST_DIV_S: begin
				rem_q <= ge ? diff[RW-1:0] : sub_a;
				quo_q <= {quo_q[NW-2:0], ge};
			end
			ST_FIN_X: begin
				cx_q  <= neg_q ? -quo_q[31:0] : quo_q[31:0];
				neg_q <= sum_y_q[SW-1];
				quo_q <= NW'(abs_y) + NW'(n_q >> 1);
				rem_q <= '0;
			end
			ST_FIN_Y: begin
				cy_q   <= neg_q ? -quo_q[31:0] : quo_q[31:0];
				dsum_q <= '0;
			end
			ST_MAG: begin
				ux_q <= dx[32] ? 33'(-dx) : 33'(dx);
				uy_q <= dy[32] ? 33'(-dy) : 33'(dy);
			end
			ST_SQX: rad_q <= 66'(ux_q * ux_q);
			ST_SQY: begin
				rad_q  <= rad_q + 66'(uy_q * uy_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= ge ? diff[RW-1:0] : sub_a;
				root_q <= {root_q[31:0], ge};
				rad_q  <= {rad_q[63:0], 2'b00};
			end
			ST_ACC: dsum_q <= dsum_q + DSW'(root_q);
			ST_PREP_S: begin
				quo_q <= NW'(SQRT2_Q32 * n_q) + NW'(dsum_q >> 1);
				rem_q <= '0;
				den_q <= RW'(dsum_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		result.centre_x    = cx_q;
		result.centre_y    = cy_q;
		result.point_count = n_ext[10:0];
		if (dsum_q == '0 || quo_q[NW-1:32] != '0) result.scale = 32'hFFFF_FFFF;
		else                                      result.scale = quo_q[31:0];
		if (ovf_q)               result.status = STATUS_OVERFLOW;
		else if (dsum_q == '0)   result.status = STATUS_ZERO;
		else                     result.status = STATUS_OK;
	end

`ifndef SYNTHESIS
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after result");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(MAX_POINTS)) else $error("point count beyond store depth");
	a_scale_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_S |-> den_q != '0) else $error("scale divide by zero");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> idx_q < n_q) else $error("store read past fill");
`endif

endmodule
`default_nettype wire
